// ===== sv/prmba_pkg.sv =====
package prmba_pkg;

    localparam int NUM_BINS  = 13;
    localparam int MAX_BEATS = 128;
    localparam int BIN_W     = $clog2(NUM_BINS);

    localparam int SMP_W  = 10;
    localparam int TIME_W = 32;
    localparam int RATE_W = 8;
    localparam int CNT_W  = 8;
    localparam int SUM_W  = 15;
    localparam int TOT_W  = 8;
    localparam int INST_W = 16;

    // shared divider: 16-bit dividend, 32-bit divisor, one quotient bit per cycle
    localparam int DIV_W  = 16;
    localparam int DVS_W  = 32;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    localparam logic [DIV_W-1:0] RATE_NUM = 16'd60000;
    localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX  = TOT_W'(MAX_BEATS);

    // rate / 10 as (rate * 205) >> 11, exact for 8-bit rates
    localparam logic [7:0] BIN_MUL   = 8'd205;
    localparam int         BIN_SHIFT = 11;

    localparam int CFG_W = 2;
    localparam logic [CFG_W-1:0] CFG_UPPER = 2'd0;
    localparam logic [CFG_W-1:0] CFG_LOWER = 2'd1;
    localparam logic [CFG_W-1:0] CFG_RMIN  = 2'd2;
    localparam logic [CFG_W-1:0] CFG_RMAX  = 2'd3;

    localparam logic [1:0] VERDICT_NORMAL = 2'd0;
    localparam logic [1:0] VERDICT_LOW    = 2'd1;
    localparam logic [1:0] VERDICT_HIGH   = 2'd2;
    localparam logic [DIV_W-1:0] LOW_LIMIT  = 16'd60;
    localparam logic [DIV_W-1:0] HIGH_LIMIT = 16'd90;

    typedef struct packed {
        logic              store;
        logic              clear;
        logic [BIN_W-1:0]  idx;
        logic [RATE_W-1:0] rate;
    } t_bin_cmd;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== sv/prmba_div.sv =====
module prmba_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  prmba_pkg::t_div_req            i_req,
    output logic                           o_done,
    output logic [prmba_pkg::DIV_W-1:0]    o_quotient
);

    logic                            r_busy;
    logic                            r_done;
    logic [prmba_pkg::DCNT_W-1:0]    r_cnt;
    logic [prmba_pkg::DIV_W-1:0]     r_dvd;
    logic [prmba_pkg::DVS_W-1:0]     r_dvs;
    logic [prmba_pkg::DVS_W:0]       r_rem;
    logic [prmba_pkg::DIV_W-1:0]     r_quo;

    logic [prmba_pkg::DVS_W:0]       w_shift;
    logic [prmba_pkg::DVS_W:0]       w_sub;
    logic                            w_ge;

    always_comb begin
        w_shift = {r_rem[prmba_pkg::DVS_W-1:0], r_dvd[prmba_pkg::DIV_W-1]};
        w_ge    = w_shift >= {1'b0, r_dvs};
        w_sub   = w_shift - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= prmba_pkg::DCNT_W'(prmba_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == prmba_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub : w_shift;
            r_quo <= {r_quo[prmba_pkg::DIV_W-2:0], w_ge};
            r_dvd <= {r_dvd[prmba_pkg::DIV_W-2:0], 1'b0};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/prmba_bins.sv =====
module prmba_bins (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  prmba_pkg::t_bin_cmd             i_cmd,
    input  logic [prmba_pkg::BIN_W-1:0]     i_rd_idx,
    output logic [prmba_pkg::CNT_W-1:0]     o_rd_count,
    output logic [prmba_pkg::SUM_W-1:0]     o_rd_sum,
    output logic                            o_empty,
    output logic                            o_full
);

    logic [prmba_pkg::CNT_W-1:0] r_count [prmba_pkg::NUM_BINS];
    logic [prmba_pkg::SUM_W-1:0] r_sum   [prmba_pkg::NUM_BINS];
    logic [prmba_pkg::TOT_W-1:0] r_total;

    logic [prmba_pkg::CNT_W-1:0] w_cnt_old;
    logic [prmba_pkg::SUM_W-1:0] w_sum_old;
    logic [prmba_pkg::SUM_W:0]   w_sum_add;
    logic [prmba_pkg::CNT_W-1:0] n_count;
    logic [prmba_pkg::SUM_W-1:0] n_sum;

    always_comb begin
        w_cnt_old = r_count[i_cmd.idx];
        w_sum_old = r_sum[i_cmd.idx];
        w_sum_add = {1'b0, w_sum_old} + (prmba_pkg::SUM_W + 1)'(i_cmd.rate);
        n_count   = (w_cnt_old == prmba_pkg::CNT_MAX) ? w_cnt_old : w_cnt_old + 1'b1;
        // saturate the running sum
        n_sum     = w_sum_add[prmba_pkg::SUM_W] ? prmba_pkg::SUM_MAX
                                                : w_sum_add[prmba_pkg::SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < prmba_pkg::NUM_BINS; k++) begin
                r_count[k] <= '0;
                r_sum[k]   <= '0;
            end
            r_total <= '0;
        end else if (i_cmd.store) begin
            r_count[i_cmd.idx] <= n_count;
            r_sum[i_cmd.idx]   <= n_sum;
            r_total            <= r_total + 1'b1;
        end
    end

    assign o_rd_count = r_count[i_rd_idx];
    assign o_rd_sum   = r_sum[i_rd_idx];
    assign o_empty    = (r_total == '0);
    assign o_full     = (r_total >= prmba_pkg::TOT_MAX);

endmodule

// ===== sv/pulse_rate_mode_bin_average.sv =====
// Path from the accepting edge to o_out_valid: a sample with no beat, a beat with a zero
// interval or a finish on an empty histogram passes EVAL and DONE; a beat with a rate passes
// EVAL, DIV_RATE (16-step shared divider), STORE and DONE; a finish passes EVAL, a scan of
// the 13 bins, AVG, DIV_AVG (the divider) and DONE. Items are taken one at a time: a new
// item is taken once the result sits in the output register, even if stalled.
// Reset (synchronous, active low) restores the default thresholds and clears detector and bins.
module pulse_rate_mode_bin_average (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_op,
    input  logic [prmba_pkg::SMP_W-1:0]       i_sample,
    input  logic [prmba_pkg::TIME_W-1:0]      i_time_ms,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_beat_start,
    output logic [prmba_pkg::INST_W-1:0]      o_inst_rate,
    output logic                              o_rate_kept,
    output logic                              o_result_valid,
    output logic [prmba_pkg::RATE_W-1:0]      o_average_rate,
    output logic [1:0]                        o_verdict,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [prmba_pkg::CFG_W-1:0]       i_cfg_index,
    input  logic [prmba_pkg::SMP_W-1:0]       i_cfg_data
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EVAL     = 3'd1;
    localparam logic [2:0] S_DIV_RATE = 3'd2;
    localparam logic [2:0] S_STORE    = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_AVG      = 3'd5;
    localparam logic [2:0] S_DIV_AVG  = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    logic [prmba_pkg::SMP_W-1:0]  r_upper;
    logic [prmba_pkg::SMP_W-1:0]  r_lower;
    logic [prmba_pkg::RATE_W-1:0] r_rate_min;
    logic [prmba_pkg::RATE_W-1:0] r_rate_max;

    logic                          r_beat_active;
    logic [prmba_pkg::TIME_W-1:0]  r_last_time;

    logic                          r_op;
    logic [prmba_pkg::SMP_W-1:0]   r_sample;
    logic [prmba_pkg::TIME_W-1:0]  r_time;

    logic [prmba_pkg::BIN_W-1:0]   r_idx;
    logic [prmba_pkg::BIN_W-1:0]   r_best;
    logic [prmba_pkg::CNT_W-1:0]   r_best_cnt;

    // staged result
    logic                          r_res_beat;
    logic [prmba_pkg::INST_W-1:0]  r_res_rate;
    logic                          r_res_kept;
    logic                          r_res_valid;
    logic [prmba_pkg::RATE_W-1:0]  r_res_avg;
    logic [1:0]                    r_res_verdict;

    // output register
    logic                          r_out_valid;
    logic                          r_out_beat;
    logic [prmba_pkg::INST_W-1:0]  r_out_rate;
    logic                          r_out_kept;
    logic                          r_out_rvalid;
    logic [prmba_pkg::RATE_W-1:0]  r_out_avg;
    logic [1:0]                    r_out_verdict;

    logic                          w_in_accept;
    logic                          w_out_free;
    logic                          w_beat;
    logic [prmba_pkg::TIME_W-1:0]  w_interval;
    logic                          w_in_range;
    logic [15:0]                   w_bin_prod;
    logic [15-prmba_pkg::BIN_SHIFT:0] w_bin;
    logic                          w_keep;

    prmba_pkg::t_div_req           w_div_req;
    logic                          w_div_done;
    logic [prmba_pkg::DIV_W-1:0]   w_quo;

    prmba_pkg::t_bin_cmd           w_bin_cmd;
    logic [prmba_pkg::BIN_W-1:0]   w_rd_idx;
    logic [prmba_pkg::CNT_W-1:0]   w_rd_count;
    logic [prmba_pkg::SUM_W-1:0]   w_rd_sum;
    logic                          w_empty;
    logic                          w_full;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_beat     = (r_sample > r_upper) && !r_beat_active;
        w_interval = r_time - r_last_time;
        w_in_range = (w_quo >= prmba_pkg::DIV_W'(r_rate_min))
                  && (w_quo <= prmba_pkg::DIV_W'(r_rate_max));
        w_bin_prod = r_res_rate[7:0] * prmba_pkg::BIN_MUL;
        w_bin      = w_bin_prod[15:prmba_pkg::BIN_SHIFT];
        w_keep     = r_res_kept && !w_full
                  && (w_bin < ($bits(w_bin))'(prmba_pkg::NUM_BINS));
    end

    always_comb begin
        w_div_req = '0;
        if (r_state == S_EVAL && !r_op && w_beat && w_interval != '0) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = prmba_pkg::RATE_NUM;
            w_div_req.divisor  = w_interval;
        end else if (r_state == S_AVG && w_rd_count != '0) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = prmba_pkg::DIV_W'(w_rd_sum);
            w_div_req.divisor  = prmba_pkg::DVS_W'(w_rd_count);
        end
    end

    always_comb begin
        w_bin_cmd       = '0;
        w_bin_cmd.idx   = w_bin[prmba_pkg::BIN_W-1:0];
        w_bin_cmd.rate  = r_res_rate[prmba_pkg::RATE_W-1:0];
        w_bin_cmd.store = (r_state == S_STORE) && w_keep;
        w_bin_cmd.clear = (r_state == S_EVAL && r_op && w_empty)
                       || (r_state == S_AVG && w_rd_count == '0)
                       || (r_state == S_DIV_AVG && w_div_done);
    end

    assign w_rd_idx = (r_state == S_SCAN) ? r_idx : r_best;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_in_accept) n_state = S_EVAL;
            S_EVAL: begin
                if (r_op) begin
                    n_state = w_empty ? S_DONE : S_SCAN;
                end else if (w_beat && w_interval != '0) begin
                    n_state = S_DIV_RATE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV_RATE: if (w_div_done) n_state = S_STORE;
            S_STORE:    n_state = S_DONE;
            S_SCAN: begin
                if (r_idx == prmba_pkg::BIN_W'(prmba_pkg::NUM_BINS - 1)) n_state = S_AVG;
            end
            S_AVG:      n_state = (w_rd_count == '0) ? S_DONE : S_DIV_AVG;
            S_DIV_AVG:  if (w_div_done) n_state = S_DONE;
            S_DONE:     if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_upper       <= 10'd485;
            r_lower       <= 10'd480;
            r_rate_min    <= 8'd50;
            r_rate_max    <= 8'd120;
            r_beat_active <= 1'b0;
            r_last_time   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    prmba_pkg::CFG_UPPER: r_upper    <= i_cfg_data;
                    prmba_pkg::CFG_LOWER: r_lower    <= i_cfg_data;
                    prmba_pkg::CFG_RMIN:  r_rate_min <= i_cfg_data[prmba_pkg::RATE_W-1:0];
                    prmba_pkg::CFG_RMAX:  r_rate_max <= i_cfg_data[prmba_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end

            // beat test first, then re-arm
            if (r_state == S_EVAL && !r_op) begin
                if (w_beat) begin
                    r_last_time <= r_time;
                end
                if (r_sample < r_lower) begin
                    r_beat_active <= 1'b0;
                end else if (w_beat) begin
                    r_beat_active <= 1'b1;
                end
            end

            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op     <= i_op;
            r_sample <= i_sample;
            r_time   <= i_time_ms;
        end

        case (r_state)
            S_EVAL: begin
                r_res_beat    <= !r_op && w_beat;
                r_res_rate    <= '0;
                r_res_kept    <= 1'b0;
                r_res_valid   <= 1'b0;
                r_res_avg     <= '0;
                r_res_verdict <= prmba_pkg::VERDICT_NORMAL;
                r_idx         <= '0;
                r_best        <= '0;
                r_best_cnt    <= '0;
            end
            S_DIV_RATE: begin
                if (w_div_done) begin
                    r_res_rate <= w_quo;
                    r_res_kept <= w_in_range;
                end
            end
            S_STORE: begin
                r_res_kept <= w_keep;
            end
            S_SCAN: begin
                // strict compare keeps the lowest bin on ties
                if (w_rd_count > r_best_cnt) begin
                    r_best     <= r_idx;
                    r_best_cnt <= w_rd_count;
                end
                r_idx <= r_idx + 1'b1;
            end
            S_AVG: begin
                r_res_valid <= 1'b1;
                r_res_verdict <= prmba_pkg::VERDICT_LOW;
            end
            S_DIV_AVG: begin
                if (w_div_done) begin
                    r_res_avg <= w_quo[prmba_pkg::RATE_W-1:0];
                    if (w_quo < prmba_pkg::LOW_LIMIT) begin
                        r_res_verdict <= prmba_pkg::VERDICT_LOW;
                    end else if (w_quo > prmba_pkg::HIGH_LIMIT) begin
                        r_res_verdict <= prmba_pkg::VERDICT_HIGH;
                    end else begin
                        r_res_verdict <= prmba_pkg::VERDICT_NORMAL;
                    end
                end
            end
            default: ;
        endcase

        if (r_state == S_DONE && w_out_free) begin
            r_out_beat    <= r_res_beat;
            r_out_rate    <= r_res_rate;
            r_out_kept    <= r_res_kept;
            r_out_rvalid  <= r_res_valid;
            r_out_avg     <= r_res_avg;
            r_out_verdict <= r_res_verdict;
        end
    end

    prmba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    prmba_bins u_bins (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_bin_cmd),
        .i_rd_idx   (w_rd_idx),
        .o_rd_count (w_rd_count),
        .o_rd_sum   (w_rd_sum),
        .o_empty    (w_empty),
        .o_full     (w_full)
    );

    assign o_out_valid    = r_out_valid;
    assign o_beat_start   = r_out_beat;
    assign o_inst_rate    = r_out_rate;
    assign o_rate_kept    = r_out_kept;
    assign o_result_valid = r_out_rvalid;
    assign o_average_rate = r_out_avg;
    assign o_verdict      = r_out_verdict;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == S_EVAL))
        else $error("accepted beat did not start evaluation");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV_RATE || r_state == S_DIV_AVG))
        else $error("divider finished outside a divide state");

    a_finish_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rvalid) |-> (!r_out_beat && !r_out_kept && r_out_rate == '0))
        else $error("finish result carries sample fields");

    a_kept_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kept) |-> (r_out_beat && r_out_rate != '0))
        else $error("stored rate without a beat");

    a_store_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bin_cmd.store |-> !w_full)
        else $error("store into a full histogram");

endmodule
